/* hw/rtl/lurs_pkg.sv */
// Shared constants and control types for the Lehmer uniform range sampler.
package lurs_pkg;

	// Widths of the request and result fields.
	localparam int unsigned BOUND_W = 32;
	localparam int unsigned STATE_W = 31;
	localparam int unsigned MULT_W  = 15;
	localparam int unsigned LPROD_W = STATE_W + MULT_W;
	localparam int unsigned RPROD_W = BOUND_W + STATE_W;

	// Park-Miller generator constants.
	localparam logic [MULT_W-1:0]  LEHMER_MULT = 15'd16807;
	localparam logic [STATE_W-1:0] LEHMER_MOD  = 31'h7FFF_FFFF;
	localparam logic [STATE_W-1:0] SEED_RESET  = 31'd12345;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic lcg_mul;
		logic lcg_fold;
		logic rng_mul;
		logic out_load;
	} lurs_cmd_t;

endpackage

/* hw/rtl/lurs_datapath.sv */
// Datapath: generator state, modular multiply, range scaling and result register.
module lurs_datapath import lurs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  lurs_cmd_t          cmd,
	input  logic               seed_we,
	input  logic [STATE_W-1:0] seed_wdata,
	input  logic [BOUND_W-1:0] low_bound,
	input  logic [BOUND_W-1:0] high_bound,
	output logic [BOUND_W-1:0] sample,
	output logic [STATE_W-1:0] raw_state
);

	logic [STATE_W-1:0] gen_q;
	logic [BOUND_W-1:0] a_q;
	logic [BOUND_W-1:0] mag_q;
	logic               neg_q;
	logic [LPROD_W-1:0] lprod_q;
	logic [RPROD_W-1:0] rprod_q;
	logic [BOUND_W-1:0] sample_q;
	logic [STATE_W-1:0] raw_q;

	logic [BOUND_W:0]   diff;
	logic [BOUND_W:0]   diff_abs;
	logic [STATE_W:0]   fold;
	logic [STATE_W-1:0] fold_red;
	logic [STATE_W-1:0] seed_red;
	logic [BOUND_W-1:0] offset;

	// Range width as a sign and a magnitude; the magnitude fits 32 bits.
	assign diff     = {high_bound[BOUND_W-1], high_bound} - {low_bound[BOUND_W-1], low_bound};
	assign diff_abs = diff[BOUND_W] ? (~diff + 1'b1) : diff;

	// Mersenne fold of the 46-bit product; the sum stays below twice the modulus.
	assign fold     = {1'b0, lprod_q[STATE_W-1:0]} + (STATE_W+1)'(lprod_q[LPROD_W-1:STATE_W]);
	assign fold_red = (fold >= {1'b0, LEHMER_MOD}) ? STATE_W'(fold - {1'b0, LEHMER_MOD})
	                                               : fold[STATE_W-1:0];

	// Seeds congruent to zero would lock the generator, so they load one.
	assign seed_red = (seed_wdata == '0 || seed_wdata == LEHMER_MOD) ? STATE_W'(1) : seed_wdata;

	// Scaled offset is the product divided by 2^31, truncated.
	assign offset = rprod_q[RPROD_W-1:STATE_W];

	// Generator state: loaded by a seed write, advanced by the fold step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= SEED_RESET;
		end else if (seed_we) begin
			gen_q <= seed_red;
		end else if (cmd.lcg_fold) begin
			gen_q <= fold_red;
		end
	end

	// Working registers and the result register.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			a_q   <= low_bound;
			mag_q <= diff_abs[BOUND_W-1:0];
			neg_q <= diff[BOUND_W];
		end
		if (cmd.lcg_mul) begin
			lprod_q <= LPROD_W'(gen_q) * LPROD_W'(LEHMER_MULT);
		end
		if (cmd.rng_mul) begin
			rprod_q <= RPROD_W'(mag_q) * RPROD_W'(gen_q);
		end
		if (cmd.out_load) begin
			sample_q <= neg_q ? (a_q - offset) : (a_q + offset);
			raw_q    <= gen_q;
		end
	end

	assign sample    = sample_q;
	assign raw_state = raw_q;

endmodule

/* hw/rtl/lurs_ctrl.sv */
// Controller: sequences one request through the datapath and owns the result valid.
module lurs_ctrl import lurs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output lurs_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LCG_MUL,
		ST_LCG_FOLD,
		ST_RNG_MUL,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// The result register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	// Commands decode directly from the current state and the handshake inputs.
	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == ST_IDLE) && in_valid;
		cmd.lcg_mul  = (state_q == ST_LCG_MUL);
		cmd.lcg_fold = (state_q == ST_LCG_FOLD);
		cmd.rng_mul  = (state_q == ST_RNG_MUL);
		cmd.out_load = (state_q == ST_FINISH) && out_free;
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LCG_MUL;
					end
				end
				ST_LCG_MUL:  state_q <= ST_LCG_FOLD;
				ST_LCG_FOLD: state_q <= ST_RNG_MUL;
				ST_RNG_MUL:  state_q <= ST_FINISH;
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/lehmer_uniform_range_sampler_top.sv */
// Top level of the Lehmer uniform range sampler.
//
// Each request carries bounds a and b in signed Q16.16 and yields one result: the
// Park-Miller generator is advanced (state * 16807 mod 2^31-1) and the block returns
// a + trunc((b-a) * state / 2^31) together with the new state. A request passes through
// accept, generator multiply, modular fold, range multiply and result load, the two
// multipliers used in sequence; a new request is taken only after the last one has
// loaded its result. The result register lets the next request start while a finished
// result still waits. Writing seed_wdata with seed_we loads the generator state at once
// (seed 0 or 2^31-1 loads state 1); the reset state is 12345. The user must make seed
// writes only while the block is idle; the block itself does not enforce this.
module lehmer_uniform_range_sampler_top import lurs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	// Seed register write port.
	input  logic         seed_we,
	input  logic [30:0]  seed_wdata,
	// Request stream.
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // [31:0] low_bound, [63:32] high_bound
	// Result stream.
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata   // [31:0] sample, [62:32] raw_state, [63] zero
);

	lurs_cmd_t          cmd;
	logic [BOUND_W-1:0] sample;
	logic [STATE_W-1:0] raw_state;

	// Sequencer.
	lurs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// Arithmetic and generator state.
	lurs_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.low_bound  (s_axis_tdata[31:0]),
		.high_bound (s_axis_tdata[63:32]),
		.sample     (sample),
		.raw_state  (raw_state)
	);

	assign m_axis_tdata = {1'b0, raw_state, sample};

endmodule
